### src/xmodem_crc_packet_receiver_macros.svh
// Assertion helpers shared by the receiver modules.
`ifndef XMODEM_CRC_PACKET_RECEIVER_MACROS_SVH
`define XMODEM_CRC_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define XCRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define XCRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/xcrc_pkg.sv
package xcrc_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int PAGE_BYTES    = 2048;

  localparam int HDR_BYTES     = 3;
  localparam int FRAME_BYTES   = HDR_BYTES + PAYLOAD_BYTES + 2;
  localparam int PAYLOAD_SHIFT = $clog2(PAYLOAD_BYTES);
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int HALF_W        = $clog2(PAYLOAD_BYTES / 2);
  localparam int SADDR_W       = HALF_W + 1;

  localparam logic [7:0]  SOH_CODE = 8'h01;
  localparam logic [7:0]  EOT_CODE = 8'h04;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NAK  = 2'd2;

  localparam logic [1:0] CMD_NAK  = 2'd0;
  localparam logic [1:0] CMD_EOT  = 2'd1;
  localparam logic [1:0] CMD_PROG = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        bank;
    logic        erase;
    logic [31:0] base;
  } cmd_t;

  typedef struct packed {
    logic               we;
    logic               odd;
    logic [SADDR_W-1:0] addr;
    logic [7:0]         data;
  } st_wr_t;

  // CRC16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/xcrc_if.sv
interface xcrc_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source(output valid, action, rx_byte, frame_last, input ready);
  modport sink(input valid, action, rx_byte, frame_last, output ready);
endinterface

interface xcrc_result_if;
  logic        valid;
  logic        ready;
  logic        program_valid;
  logic        erase_before;
  logic [31:0] flash_addr;
  logic [15:0] halfword_data;
  logic [1:0]  reply;
  logic        last;

  modport source(output valid, program_valid, erase_before, flash_addr, halfword_data,
                 reply, last, input ready);
  modport sink(input valid, program_valid, erase_before, flash_addr, halfword_data,
               reply, last, output ready);
endinterface

### src/xcrc_store.sv
module xcrc_store import xcrc_pkg::*; (
  input  logic               clk,
  input  st_wr_t             wr,
  input  logic [SADDR_W-1:0] rd_addr,
  output logic [15:0]        rd_data
);

  // two packet buffers, even and odd bytes kept apart for halfword reads
  logic [7:0] even_mem [0:(1 << SADDR_W)-1];
  logic [7:0] odd_mem  [0:(1 << SADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr.we && !wr.odd) begin
      even_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.odd) begin
      odd_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= {odd_mem[rd_addr], even_mem[rd_addr]};
  end

endmodule

### src/xcrc_fifo.sv
`include "xmodem_crc_packet_receiver_macros.svh"

module xcrc_fifo import xcrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t       entry [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  `XCRC_ASSERT_IMP(a_no_push_full, clk, rst, push, !full, "command pushed into full queue")
  `XCRC_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty, "command popped from empty queue")

endmodule

### src/xcrc_front.sv
`include "xmodem_crc_packet_receiver_macros.svh"

module xcrc_front import xcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  xcrc_item_if.sink   items,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data,
  input  logic        done,
  output st_wr_t      wr
);

  logic [31:0] region_base;
  logic [7:0]  frame_length;
  logic [7:0]  start_byte;
  logic [7:0]  seq_number;
  logic [7:0]  seq_complement;
  logic [15:0] running_crc;
  logic [15:0] received_crc;
  logic [15:0] accepted_packets;
  logic        wr_bank;
  logic [1:0]  busy_cnt;
  logic [1:0]  busy_cnt_next;

  logic [7:0]  start_next, seq_next, comp_next, len_next;
  logic [15:0] crc_next, rcrc_next;
  logic [8:0]  seq_sum;
  logic [6:0]  byte_idx;
  logic        accept, in_payload, is_soh, is_eot, good, push_prog;
  logic [31:0] offs;

  // hold off input while both buffers are held by pending packets or the command queue is full
  assign items.ready = !q_full && (busy_cnt != 2'd2);
  assign accept      = items.valid && items.ready;

  assign in_payload = (frame_length >= 8'(HDR_BYTES)) &&
                      (frame_length < 8'(HDR_BYTES + PAYLOAD_BYTES));
  assign byte_idx   = 7'(frame_length - 8'(HDR_BYTES));

  always_comb begin
    start_next = start_byte;
    seq_next   = seq_number;
    comp_next  = seq_complement;
    crc_next   = running_crc;
    rcrc_next  = received_crc;
    if (frame_length == 8'd0) begin
      start_next = items.rx_byte;
    end else if (frame_length == 8'd1) begin
      seq_next = items.rx_byte;
    end else if (frame_length == 8'd2) begin
      comp_next = items.rx_byte;
    end else if (in_payload) begin
      crc_next = crc_byte(running_crc, items.rx_byte);
    end else if (frame_length == 8'(HDR_BYTES + PAYLOAD_BYTES)) begin
      rcrc_next = {items.rx_byte, received_crc[7:0]};
    end else if (frame_length == 8'(HDR_BYTES + PAYLOAD_BYTES + 1)) begin
      rcrc_next = {received_crc[15:8], items.rx_byte};
    end
    len_next = (frame_length == 8'hFF) ? 8'hFF : 8'(frame_length + 8'd1);
  end

  assign seq_sum = {1'b0, seq_next} + {1'b0, comp_next};
  assign is_soh  = (len_next == 8'(FRAME_BYTES)) && (start_next == SOH_CODE);
  assign is_eot  = (len_next == 8'd1) && (start_next == EOT_CODE);
  assign good    = (seq_sum == 9'h0FF) && (crc_next == rcrc_next);

  assign q_push    = accept && items.action && items.frame_last && (is_soh || is_eot);
  assign push_prog = q_push && is_soh && good;

  assign offs = 32'(accepted_packets) << PAYLOAD_SHIFT;

  always_comb begin
    q_data.bank  = wr_bank;
    q_data.erase = (offs[PAGE_SHIFT-1:0] == '0);
    q_data.base  = region_base + offs;
    if (!is_soh) begin
      q_data.kind = CMD_EOT;
    end else if (good) begin
      q_data.kind = CMD_PROG;
    end else begin
      q_data.kind = CMD_NAK;
    end
  end

  assign wr.we   = accept && items.action && in_payload;
  assign wr.odd  = byte_idx[0];
  assign wr.addr = {wr_bank, byte_idx[6:1]};
  assign wr.data = items.rx_byte;

  assign busy_cnt_next = 2'(busy_cnt + {1'b0, push_prog} - {1'b0, done});

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base      <= '0;
      frame_length     <= '0;
      start_byte       <= '0;
      seq_number       <= '0;
      seq_complement   <= '0;
      running_crc      <= '0;
      received_crc     <= '0;
      accepted_packets <= '0;
      wr_bank          <= 1'b0;
      busy_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        region_base <= cfg_wdata;
      end
      busy_cnt <= busy_cnt_next;
      if (accept) begin
        if (!items.action || items.frame_last) begin
          frame_length   <= '0;
          start_byte     <= '0;
          seq_number     <= '0;
          seq_complement <= '0;
          running_crc    <= '0;
          received_crc   <= '0;
        end else begin
          frame_length   <= len_next;
          start_byte     <= start_next;
          seq_number     <= seq_next;
          seq_complement <= comp_next;
          running_crc    <= crc_next;
          received_crc   <= rcrc_next;
        end
        if (!items.action) begin
          accepted_packets <= '0;
        end else if (push_prog) begin
          accepted_packets <= 16'(accepted_packets + 16'd1);
          wr_bank          <= !wr_bank;
        end
      end
    end
  end

  `XCRC_ASSERT_IMP(a_busy_bound, clk, rst, 1'b1, busy_cnt != 2'd3, "buffer count overflow")
  `XCRC_ASSERT_IMP(a_done_busy, clk, rst, done, busy_cnt != 2'd0, "packet done with none pending")

endmodule

### src/xcrc_back.sv
`include "xmodem_crc_packet_receiver_macros.svh"

module xcrc_back import xcrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic [SADDR_W-1:0] rd_addr,
  input  logic [15:0]        rd_data,
  output logic               done,
  xcrc_result_if.source      results
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SINGLE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_DATA   = 2'd3;

  localparam logic [HALF_W-1:0] K_LAST = HALF_W'(PAYLOAD_BYTES / 2 - 1);

  logic [1:0]        state;
  cmd_t              cmd;
  logic [HALF_W-1:0] k;
  logic              out_valid;
  logic              out_pv, out_erase, out_last;
  logic [31:0]       out_addr;
  logic [15:0]       out_data;
  logic [1:0]        out_reply;
  logic              load, k_last;

  assign k_last  = (k == K_LAST);
  assign load    = ((state == S_SINGLE) || (state == S_DATA)) &&
                   (!out_valid || results.ready);
  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign rd_addr = {cmd.bank, k};
  assign done    = load && (state == S_DATA) && k_last;

  assign results.valid         = out_valid;
  assign results.program_valid = out_pv;
  assign results.erase_before  = out_erase;
  assign results.flash_addr    = out_addr;
  assign results.halfword_data = out_data;
  assign results.reply         = out_reply;
  assign results.last          = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            k     <= '0;
            state <= (q_data.kind == CMD_PROG) ? S_READ : S_SINGLE;
          end
        end
        S_SINGLE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (load) begin
            if (k_last) begin
              state <= S_IDLE;
            end else begin
              k     <= HALF_W'(k + 1'b1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (load) begin
      if (state == S_SINGLE) begin
        out_pv    <= 1'b0;
        out_erase <= 1'b0;
        out_addr  <= '0;
        out_data  <= '0;
        out_reply <= (cmd.kind == CMD_NAK) ? REPLY_NAK : REPLY_ACK;
        out_last  <= 1'b1;
      end else begin
        out_pv    <= 1'b1;
        out_erase <= cmd.erase && (k == '0);
        out_addr  <= cmd.base + 32'({k, 1'b0});
        out_data  <= rd_data;
        out_reply <= k_last ? REPLY_ACK : REPLY_NONE;
        out_last  <= k_last;
      end
    end
  end

  `XCRC_ASSERT_IMP(a_last_reply, clk, rst, out_valid && out_last, out_reply != REPLY_NONE, "final result without reply")
  `XCRC_ASSERT_NXT(a_stall_hold, clk, rst, (state == S_DATA) && out_valid && !results.ready, (state == S_DATA) && $stable(k), "halfword index moved under stall")

endmodule

### src/xmodem_crc_packet_receiver.sv
// An EOT/NAK reply passes the command queue, single-result state and output register;
// a good packet's first halfword program: queue, buffer read state, output register.
// Throughput: one byte per cycle on input unless two packets wait or the queue is full;
// each halfword program takes a buffer read then an output load.
// Reset (rst, synchronous): clears frame state, packet count, base register and queues;
// the packet buffers are not cleared.
module xmodem_crc_packet_receiver import xcrc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  xcrc_item_if.sink     items,
  xcrc_result_if.source results,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  logic               q_push, q_pop, q_full, q_empty, done;
  cmd_t               q_in, q_out;
  st_wr_t             wr;
  logic [SADDR_W-1:0] rd_addr;
  logic [15:0]        rd_data;

  xcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in),
    .done      (done),
    .wr        (wr)
  );

  xcrc_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xcrc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  xcrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (done),
    .results (results)
  );

endmodule
